// ===== design/barometer_compensation_top_macros.svh =====
// Assertion macros for the barometer compensation top level.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef BAROMETER_COMPENSATION_TOP_MACROS_SVH
`define BAROMETER_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define BARO_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define BARO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/baro_pkg.sv =====
// Shared widths, constants and register indexes for the barometer compensation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package baro_pkg;
    localparam int RAW_T_W  = 16;
    localparam int RAW_P_W  = 19;
    localparam int TEMP_W   = 14;
    localparam int PRESS_W  = 18;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 2;
    localparam int DIV_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEFFS_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OSS      = 2'd3;

    localparam logic [31:0] C_B6_OFS  = 32'd4000;
    localparam logic [31:0] C_X1_K    = 32'd3038;
    localparam logic [31:0] C_X2_K    = 32'hFFFF_E343;  // -7357
    localparam logic [31:0] C_P_OFS   = 32'd3791;
    localparam logic [31:0] C_B7_K    = 32'd50000;
    localparam logic [31:0] C_B4_OFS  = 32'd32768;
endpackage
`default_nettype wire

// ===== design/baro_in_if.sv =====
// Input channel: one raw temperature and pressure reading per transaction.
// Depends on baro_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface baro_in_if import baro_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RAW_T_W-1:0] raw_temperature;
    logic [RAW_P_W-1:0] raw_pressure;

    modport source (output valid, output raw_temperature, output raw_pressure, input ready);
    modport sink   (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface
`default_nettype wire

// ===== design/baro_out_if.sv =====
// Output channel: one compensated result per transaction.
// Depends on baro_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface baro_out_if import baro_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature;
    logic        [PRESS_W-1:0] pressure;
    logic                      div_fault;

    modport source (output valid, output temperature, output pressure, output div_fault,
                    input ready);
    modport sink   (input valid, input temperature, input pressure, input div_fault,
                    output ready);
endinterface
`default_nettype wire

// ===== design/baro_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage, with sideband.
// Depends on baro_pkg.
`timescale 1ns / 1ps
`default_nettype none
module baro_div import baro_pkg::*; #(
    parameter int WIDTH = DIV_W,
    parameter int PL_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] num,
    input  logic [WIDTH-1:0] den,
    input  logic [PL_W-1:0]  in_pl,
    output logic             out_valid,
    output logic [WIDTH-1:0] quo,
    output logic [PL_W-1:0]  out_pl
);
    logic [WIDTH-1:0] rem_reg [WIDTH];
    logic [WIDTH-1:0] num_reg [WIDTH];
    logic [WIDTH-1:0] den_reg [WIDTH];
    logic [PL_W-1:0]  pl_reg  [WIDTH];
    logic [WIDTH-1:0] vld_reg;

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        logic [WIDTH-1:0] rem_in, num_in, den_in, rem_next, num_next;
        logic [PL_W-1:0]  pl_in;
        logic             vld_in;
        logic [WIDTH:0]   sh, diff;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign pl_in  = in_pl;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign pl_in  = pl_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        assign sh       = {rem_in, num_in[WIDTH-1]};
        assign ge       = sh >= {1'b0, den_in};
        assign diff     = sh - {1'b0, den_in};
        assign rem_next = ge ? diff[WIDTH-1:0] : sh[WIDTH-1:0];
        assign num_next = {num_in[WIDTH-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                num_reg[k] <= num_next;
                den_reg[k] <= den_in;
                pl_reg[k]  <= pl_in;
            end
        end
    end

    assign out_valid = vld_reg[WIDTH-1];
    assign quo       = num_reg[WIDTH-1];
    assign out_pl    = pl_reg[WIDTH-1];
endmodule
`default_nettype wire

// ===== design/barometer_compensation_top.sv =====
// Barometer compensation top level: calibration registers, arithmetic stages,
// two pipelined dividers. Depends on baro_pkg, baro_in_if, baro_out_if, baro_div.
//
//  channel   dir  payload                                   handshake
//  sample    in   raw_temperature[16], raw_pressure[19]     valid/ready
//  result    out  temperature[14] s, pressure[18], div_fault valid/ready
//  cfg       in   cfg_index[2], cfg_data[64]                cfg_we, no wait
//
// One transaction per cycle while the output is not stalled; stages: 32 per divider, 10 arithmetic.
// The whole pipeline advances together whenever the output register is empty or taken.
// rst_n clears all valid bits and loads the calibration reset values.
// While the output is stalled, sample.ready is low and nothing moves.
`timescale 1ns / 1ps
`default_nettype none
module barometer_compensation_top import baro_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    baro_in_if.sink              sample,
    baro_out_if.source           result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);
    localparam int PL1_W = 32 + RAW_P_W + 2;
    localparam int PL2_W = TEMP_W + 2;

    logic [63:0] cal_a_reg, cal_b_reg;
    logic [31:0] cal_c_reg;
    logic [1:0]  oss_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
            oss_reg   <= 2'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEFFS_A: cal_a_reg <= cfg_data;
                CFG_COEFFS_B: cal_b_reg <= cfg_data;
                CFG_COEFFS_C: cal_c_reg <= cfg_data[31:0];
                CFG_OSS:      oss_reg   <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = {{16{cal_a_reg[63]}}, cal_a_reg[63:48]};
    assign ac2 = {{16{cal_a_reg[47]}}, cal_a_reg[47:32]};
    assign ac3 = {{16{cal_a_reg[31]}}, cal_a_reg[31:16]};
    assign ac4 = {16'b0, cal_a_reg[15:0]};
    assign ac5 = {16'b0, cal_b_reg[63:48]};
    assign ac6 = {16'b0, cal_b_reg[47:32]};
    assign b1  = {{16{cal_b_reg[31]}}, cal_b_reg[31:16]};
    assign b2  = {{16{cal_b_reg[15]}}, cal_b_reg[15:0]};
    assign mc  = {{16{cal_c_reg[31]}}, cal_c_reg[31:16]};
    assign md  = {{16{cal_c_reg[15]}}, cal_c_reg[15:0]};

    logic en;
    logic out_vld_reg;
    assign en           = !out_vld_reg || result.ready;
    assign sample.ready = en;

    // stage 1: x1 and the temperature divisor
    logic              s1_vld_reg;
    logic [31:0]       s1_x1_reg, s1_den_reg;
    logic [RAW_P_W-1:0] s1_up_reg;
    logic [31:0]       ut_diff, x1_next;
    assign ut_diff = {16'b0, sample.raw_temperature} - ac6;
    assign x1_next = 32'($signed(ut_diff * ac5) >>> 15);

    // temperature divider, signed via magnitudes
    logic [31:0] mc_sh, num1, den1, q1;
    logic [PL1_W-1:0] pl1_in, pl1_out;
    logic        d1_vld;
    assign mc_sh  = mc << 11;
    assign num1   = mc_sh[31] ? (32'd0 - mc_sh) : mc_sh;
    assign den1   = s1_den_reg[31] ? (32'd0 - s1_den_reg) : s1_den_reg;
    assign pl1_in = {s1_x1_reg, s1_up_reg, mc_sh[31] ^ s1_den_reg[31], s1_den_reg == '0};

    baro_div #(.WIDTH(DIV_W), .PL_W(PL1_W)) u_div_t (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s1_vld_reg),
        .num(num1), .den(den1), .in_pl(pl1_in),
        .out_valid(d1_vld), .quo(q1), .out_pl(pl1_out)
    );

    // stage 3: b5, temperature, b6
    logic [31:0]        d1_x1, x2_t, b5, tt, b6_next;
    logic [RAW_P_W-1:0] d1_up;
    logic               d1_neg, d1_fault;
    logic [TEMP_W-1:0]  tsat_next;
    assign {d1_x1, d1_up, d1_neg, d1_fault} = pl1_out;
    assign x2_t    = d1_neg ? (32'd0 - q1) : q1;
    assign b5      = d1_x1 + x2_t;
    assign tt      = 32'($signed(b5 + 32'd8) >>> 4);
    assign b6_next = b5 - C_B6_OFS;
    always_comb
    begin
        if ($signed(tt) < -32'sd8192)
            tsat_next = TEMP_W'(14'h2000);
        else if ($signed(tt) > 32'sd8191)
            tsat_next = TEMP_W'(14'h1FFF);
        else
            tsat_next = tt[TEMP_W-1:0];
    end

    logic s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic s10_vld_reg, s11_vld_reg;
    logic [TEMP_W-1:0]  s3_t_reg, s4_t_reg, s5_t_reg, s6_t_reg, s7_t_reg, s8_t_reg;
    logic [TEMP_W-1:0]  s10_t_reg, s11_t_reg;
    logic [RAW_P_W-1:0] s3_up_reg, s4_up_reg, s5_up_reg, s6_up_reg;
    logic s3_f_reg, s4_f_reg, s5_f_reg, s6_f_reg, s7_f_reg, s8_f_reg, s10_f_reg, s11_f_reg;
    logic [31:0] s3_b6_reg;
    logic [31:0] s4_sq_reg, s4_x2b_reg, s4_x1c_reg;
    logic [31:0] s5_x1b_reg, s5_x2c_reg, s5_x2b_reg, s5_x1c_reg;
    logic [31:0] s6_b3_reg, s6_x3c_reg;
    logic [31:0] s7_b4_reg, s7_diff_reg;
    logic [31:0] s8_b7_reg, s8_b4_reg;
    logic [31:0] s10_p_reg, s10_sq_reg, s10_x2_reg;
    logic [31:0] s11_p_reg, s11_x1_reg, s11_x2_reg;

    // stage 4..8 combinational terms
    logic [31:0] sq_next, x2b_next, x1c_next, x1b_next, x2c_next;
    logic [31:0] x3, t1, t2, b3_next, x3c_next, b4_next, diff_next, b7_next;
    assign sq_next   = 32'($signed(s3_b6_reg * s3_b6_reg) >>> 12);
    assign x2b_next  = 32'($signed(ac2 * s3_b6_reg) >>> 11);
    assign x1c_next  = 32'($signed(ac3 * s3_b6_reg) >>> 13);
    assign x1b_next  = 32'($signed(b2 * s4_sq_reg) >>> 11);
    assign x2c_next  = 32'($signed(b1 * s4_sq_reg) >>> 16);
    assign x3        = s5_x1b_reg + s5_x2b_reg;
    assign t1        = (ac1 << 2) + x3;
    assign t2        = (t1 << oss_reg) + 32'd2;
    assign b3_next   = 32'($signed(t2) >>> 2);
    assign x3c_next  = 32'($signed(s5_x1c_reg + s5_x2c_reg + 32'd2) >>> 2);
    assign b4_next   = (ac4 * (s6_x3c_reg + C_B4_OFS)) >> 15;
    assign diff_next = {13'b0, s6_up_reg} - s6_b3_reg;
    assign b7_next   = s7_diff_reg * (C_B7_K >> oss_reg);

    // pressure divider
    logic [31:0]      num2, q2;
    logic [PL2_W-1:0] pl2_in, pl2_out;
    logic             d2_vld;
    assign num2   = s8_b7_reg[31] ? s8_b7_reg : (s8_b7_reg << 1);
    assign pl2_in = {s8_t_reg, s8_f_reg, s8_b7_reg[31]};

    baro_div #(.WIDTH(DIV_W), .PL_W(PL2_W)) u_div_p (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s8_vld_reg),
        .num(num2), .den(s8_b4_reg), .in_pl(pl2_in),
        .out_valid(d2_vld), .quo(q2), .out_pl(pl2_out)
    );

    logic [TEMP_W-1:0] d2_t;
    logic              d2_f, d2_hi;
    logic [31:0]       p_next, pp, psq_next, px2_next, px1_next, pf, corr;
    assign {d2_t, d2_f, d2_hi} = pl2_out;
    assign p_next   = d2_hi ? (q2 << 1) : q2;
    assign pp       = 32'($signed(p_next) >>> 8);
    assign psq_next = pp * pp;
    assign px2_next = 32'($signed(C_X2_K * p_next) >>> 16);
    assign px1_next = 32'($signed(s10_sq_reg * C_X1_K) >>> 16);
    assign corr     = 32'($signed(s11_x1_reg + s11_x2_reg + C_P_OFS) >>> 4);
    assign pf       = s11_p_reg + corr;

    logic [PRESS_W-1:0] press_next;
    logic [TEMP_W-1:0]  temp_next;
    always_comb
    begin
        if (pf[31])
            press_next = '0;
        else if (pf > 32'd262143)
            press_next = '1;
        else
            press_next = pf[PRESS_W-1:0];
        temp_next = s11_t_reg;
        if (s11_f_reg)
        begin
            press_next = '0;
            temp_next  = '0;
        end
    end

    logic [TEMP_W-1:0]  out_t_reg;
    logic [PRESS_W-1:0] out_p_reg;
    logic               out_f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            s11_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg  <= sample.valid;
            s3_vld_reg  <= d1_vld;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s10_vld_reg <= d2_vld;
            s11_vld_reg <= s10_vld_reg;
            out_vld_reg <= s11_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x1_reg   <= x1_next;
            s1_den_reg  <= x1_next + md;
            s1_up_reg   <= sample.raw_pressure;

            s3_t_reg    <= tsat_next;
            s3_up_reg   <= d1_up;
            s3_f_reg    <= d1_fault;
            s3_b6_reg   <= b6_next;

            s4_t_reg    <= s3_t_reg;
            s4_up_reg   <= s3_up_reg;
            s4_f_reg    <= s3_f_reg;
            s4_sq_reg   <= sq_next;
            s4_x2b_reg  <= x2b_next;
            s4_x1c_reg  <= x1c_next;

            s5_t_reg    <= s4_t_reg;
            s5_up_reg   <= s4_up_reg;
            s5_f_reg    <= s4_f_reg;
            s5_x1b_reg  <= x1b_next;
            s5_x2c_reg  <= x2c_next;
            s5_x2b_reg  <= s4_x2b_reg;
            s5_x1c_reg  <= s4_x1c_reg;

            s6_t_reg    <= s5_t_reg;
            s6_up_reg   <= s5_up_reg;
            s6_f_reg    <= s5_f_reg;
            s6_b3_reg   <= b3_next;
            s6_x3c_reg  <= x3c_next;

            s7_t_reg    <= s6_t_reg;
            s7_f_reg    <= s6_f_reg;
            s7_b4_reg   <= b4_next;
            s7_diff_reg <= diff_next;

            s8_t_reg    <= s7_t_reg;
            s8_f_reg    <= s7_f_reg || (s7_b4_reg == '0);
            s8_b7_reg   <= b7_next;
            s8_b4_reg   <= s7_b4_reg;

            s10_t_reg   <= d2_t;
            s10_f_reg   <= d2_f;
            s10_p_reg   <= p_next;
            s10_sq_reg  <= psq_next;
            s10_x2_reg  <= px2_next;

            s11_t_reg   <= s10_t_reg;
            s11_f_reg   <= s10_f_reg;
            s11_p_reg   <= s10_p_reg;
            s11_x1_reg  <= px1_next;
            s11_x2_reg  <= s10_x2_reg;

            out_t_reg   <= temp_next;
            out_p_reg   <= press_next;
            out_f_reg   <= s11_f_reg;
        end
    end

    assign result.valid       = out_vld_reg;
    assign result.temperature = out_t_reg;
    assign result.pressure    = out_p_reg;
    assign result.div_fault   = out_f_reg;

`include "barometer_compensation_top_macros.svh"

    `BARO_ASSERT_NOW(a_fault_zero, result.valid && result.div_fault, result.temperature == '0 && result.pressure == '0, "fault result carries nonzero data")
    `BARO_ASSERT_NEXT(a_stall_hold, !en, $stable(s3_vld_reg) && $stable(s8_vld_reg) && $stable(s11_vld_reg), "pipeline moved during stall")
endmodule
`default_nettype wire
